// File: rtl/fadd_pkg.sv
// ----------------------------------------------------------------------------
// fadd_pkg
// Shared widths, item types and codes for the fraction adder with reduction.
// ----------------------------------------------------------------------------
package fadd_pkg;

   // operand width of one numerator; denominators are one bit narrower
   localparam int VALUE_BITS = 16;
   localparam int DEN_IN_W   = VALUE_BITS - 1;
   localparam int NUM_W      = 2 * VALUE_BITS;
   localparam int DEN_W      = 2 * VALUE_BITS - 2;
   localparam int WHOLE_W    = 2 * VALUE_BITS - 1;
   // magnitudes handled by the gcd and divide units
   localparam int MAG_W      = WHOLE_W;
   localparam int STEP_W     = $clog2(MAG_W);

   // result classification
   typedef enum logic [1:0] {
      FORM_INTEGER = 2'd0,
      FORM_MIXED   = 2'd1,
      FORM_PROPER  = 2'd2
   } form_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_AD,
      ST_MUL_CB,
      ST_MUL_BD,
      ST_GCD_GO,
      ST_GCD_WAIT,
      ST_NUM_GO,
      ST_NUM_WAIT,
      ST_DEN_GO,
      ST_DEN_WAIT,
      ST_CLASSIFY,
      ST_MIX_GO,
      ST_MIX_WAIT,
      ST_FINISH
   } state_type;

   // status reported by an iterative unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] first_numerator;
      logic [DEN_IN_W-1:0]          first_denominator;
      logic signed [VALUE_BITS-1:0] second_numerator;
      logic [DEN_IN_W-1:0]          second_denominator;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] raw_numerator;
      logic [DEN_W-1:0]        raw_denominator;
      logic signed [NUM_W-1:0] reduced_numerator;
      logic [DEN_W-1:0]        reduced_denominator;
      logic [WHOLE_W-1:0]      whole_part;
      logic [DEN_W-1:0]        remainder_numerator;
      form_type                form;
   } rsp_type;

endpackage

// File: rtl/fadd_mul.sv
// ----------------------------------------------------------------------------
// fadd_mul
// Shared signed multiplier with a registered product, one product per cycle.
// ----------------------------------------------------------------------------
module fadd_mul (
   input  logic                                  clock,
   input  logic signed [fadd_pkg::VALUE_BITS-1:0] op_a,
   input  logic signed [fadd_pkg::VALUE_BITS-1:0] op_b,
   output logic signed [fadd_pkg::NUM_W-1:0]      product_ff
);

   // product register, operands sign-extended to the product width
   always_ff @(posedge clock) begin
      product_ff <= fadd_pkg::NUM_W'(op_a) * fadd_pkg::NUM_W'(op_b);
   end

endmodule

// File: rtl/fadd_gcd.sv
// ----------------------------------------------------------------------------
// fadd_gcd
// Binary gcd: one compare, subtract or shift step per cycle.
// ----------------------------------------------------------------------------
module fadd_gcd (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [fadd_pkg::MAG_W-1:0]         x_value,
   input  logic [fadd_pkg::MAG_W-1:0]         y_value,
   output fadd_pkg::unit_status_type          status,
   output logic [fadd_pkg::MAG_W-1:0]         gcd_ff
);

   logic [fadd_pkg::MAG_W-1:0]  u_ff, u_in, v_ff, v_in, gcd_in;
   logic [fadd_pkg::STEP_W-1:0] k_ff, k_in;
   logic                        busy_ff, busy_in, done_ff, done_in;

   // one reduction step
   always_comb begin
      u_in    = u_ff;
      v_in    = v_ff;
      k_in    = k_ff;
      gcd_in  = gcd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         u_in    = x_value;
         v_in    = y_value;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         priority if (u_ff == '0) begin
            gcd_in  = v_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (v_ff == '0) begin
            gcd_in  = u_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_in = u_ff - v_ff;
         end else begin
            v_in = v_ff - u_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      u_ff   <= u_in;
      v_ff   <= v_in;
      k_ff   <= k_in;
      gcd_ff <= gcd_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: rtl/fadd_div.sv
// ----------------------------------------------------------------------------
// fadd_div
// Restoring divider: one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module fadd_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [fadd_pkg::MAG_W-1:0]         dividend,
   input  logic [fadd_pkg::MAG_W-1:0]         divisor,
   output fadd_pkg::unit_status_type          status,
   output logic [fadd_pkg::MAG_W-1:0]         quot_ff,
   output logic [fadd_pkg::MAG_W-1:0]         rem_ff
);

   logic [fadd_pkg::MAG_W-1:0]  quot_in, rem_in, dsr_ff, dsr_in;
   logic [fadd_pkg::STEP_W-1:0] count_ff, count_in;
   logic                        busy_ff, busy_in, done_ff, done_in;
   logic [fadd_pkg::MAG_W:0]    trial;

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, quot_ff[fadd_pkg::MAG_W-1]} - {1'b0, dsr_ff};
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[fadd_pkg::MAG_W]) begin
            rem_in  = trial[fadd_pkg::MAG_W-1:0];
            quot_in = {quot_ff[fadd_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[fadd_pkg::MAG_W-2:0], quot_ff[fadd_pkg::MAG_W-1]};
            quot_in = {quot_ff[fadd_pkg::MAG_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == fadd_pkg::STEP_W'(fadd_pkg::MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      count_ff <= count_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: rtl/fraction_add_and_reduce.sv
// ----------------------------------------------------------------------------
// fraction_add_and_reduce
// Adds two signed fractions and reduces the sum to lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one item: two fractions a/b and c/d
//   with b and d positive (a zero denominator counts as one). rsp_valid/
//   rsp_stall/rsp_data return one item per input: the raw sum (a*d+c*b)/(b*d),
//   the pair divided by the gcd of the magnitudes, whole part, remainder and
//   form code (integer, mixed or proper/negative).
//   One item is worked at a time; req_stall is high from acceptance until
//   the result is loaded into the output register. The steps run in order:
//   three products on the multiplier, a binary gcd of the 31-bit magnitudes,
//   then restoring divisions of the numerator and the denominator by the gcd,
//   and of the two quotients for a mixed number. The next item can be
//   accepted in the cycle after the load.
//   The output register holds a finished item while rsp_stall is high; a new
//   item can be accepted then, and its result waits until the slot frees.
//   Synchronous reset returns the sequencer to idle and clears rsp_valid.
// ----------------------------------------------------------------------------
module fraction_add_and_reduce (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fadd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fadd_pkg::rsp_type rsp_data
);

   fadd_pkg::state_type state_ff, state_in;

   logic signed [fadd_pkg::VALUE_BITS-1:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [fadd_pkg::VALUE_BITS-1:0] mul_a, mul_b;
   logic signed [fadd_pkg::NUM_W-1:0]      product_ff, rnum_ff;
   logic [fadd_pkg::DEN_W-1:0]             rden_ff;
   logic [fadd_pkg::MAG_W-1:0]             mag, qmag_ff, qden_ff, whole_ff, rem_ff;
   logic [fadd_pkg::MAG_W-1:0]             gcd_value, div_a, div_b, quot, div_rem;
   logic                                   gcd_start, div_start, load_rsp, rsp_valid_ff;
   fadd_pkg::form_type                     form_ff;
   fadd_pkg::unit_status_type              gcd_status, div_status;
   fadd_pkg::rsp_type                      rsp_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      gcd_start = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         fadd_pkg::ST_IDLE:     if (req_valid) state_in = fadd_pkg::ST_MUL_AD;
         fadd_pkg::ST_MUL_AD:   state_in = fadd_pkg::ST_MUL_CB;
         fadd_pkg::ST_MUL_CB:   state_in = fadd_pkg::ST_MUL_BD;
         fadd_pkg::ST_MUL_BD:   state_in = fadd_pkg::ST_GCD_GO;
         fadd_pkg::ST_GCD_GO: begin
            gcd_start = 1'b1;
            state_in  = fadd_pkg::ST_GCD_WAIT;
         end
         fadd_pkg::ST_GCD_WAIT: if (gcd_status.done) state_in = fadd_pkg::ST_NUM_GO;
         fadd_pkg::ST_NUM_GO: begin
            div_start = 1'b1;
            state_in  = fadd_pkg::ST_NUM_WAIT;
         end
         fadd_pkg::ST_NUM_WAIT: if (div_status.done) state_in = fadd_pkg::ST_DEN_GO;
         fadd_pkg::ST_DEN_GO: begin
            div_start = 1'b1;
            state_in  = fadd_pkg::ST_DEN_WAIT;
         end
         fadd_pkg::ST_DEN_WAIT: if (div_status.done) state_in = fadd_pkg::ST_CLASSIFY;
         fadd_pkg::ST_CLASSIFY: begin
            if (qden_ff != fadd_pkg::MAG_W'(1) && qmag_ff != '0 && !rnum_ff[fadd_pkg::NUM_W-1]
                && qmag_ff > qden_ff) begin
               state_in = fadd_pkg::ST_MIX_GO;
            end else begin
               state_in = fadd_pkg::ST_FINISH;
            end
         end
         fadd_pkg::ST_MIX_GO: begin
            div_start = 1'b1;
            state_in  = fadd_pkg::ST_MIX_WAIT;
         end
         fadd_pkg::ST_MIX_WAIT: if (div_status.done) state_in = fadd_pkg::ST_FINISH;
         fadd_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = fadd_pkg::ST_IDLE;
            end
         end
         default:               state_in = fadd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fadd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != fadd_pkg::ST_IDLE);

   // multiplier operand select
   always_comb begin
      unique case (state_ff)
         fadd_pkg::ST_MUL_AD: begin
            mul_a = a_ff;
            mul_b = d_ff;
         end
         fadd_pkg::ST_MUL_CB: begin
            mul_a = c_ff;
            mul_b = b_ff;
         end
         default: begin
            mul_a = b_ff;
            mul_b = d_ff;
         end
      endcase
   end

   fadd_mul u_mul (
      .clock      (clock),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .product_ff (product_ff)
   );

   // magnitude of the raw numerator
   always_comb begin
      logic [fadd_pkg::NUM_W-1:0] neg;
      neg = -rnum_ff;
      mag = rnum_ff[fadd_pkg::NUM_W-1] ? neg[fadd_pkg::MAG_W-1:0]
                                       : rnum_ff[fadd_pkg::MAG_W-1:0];
   end

   // the denominator product is still on the multiplier output at gcd start
   fadd_gcd u_gcd (
      .clock   (clock),
      .reset   (reset),
      .start   (gcd_start),
      .x_value (mag),
      .y_value ({1'b0, product_ff[fadd_pkg::DEN_W-1:0]}),
      .status  (gcd_status),
      .gcd_ff  (gcd_value)
   );

   // divider operand select
   always_comb begin
      unique case (state_ff)
         fadd_pkg::ST_NUM_GO: begin
            div_a = mag;
            div_b = gcd_value;
         end
         fadd_pkg::ST_DEN_GO: begin
            div_a = {1'b0, rden_ff};
            div_b = gcd_value;
         end
         default: begin
            div_a = qmag_ff;
            div_b = qden_ff;
         end
      endcase
   end

   fadd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .status   (div_status),
      .quot_ff  (quot),
      .rem_ff   (div_rem)
   );

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         fadd_pkg::ST_IDLE: begin
            a_ff <= req_data.first_numerator;
            c_ff <= req_data.second_numerator;
            b_ff <= (req_data.first_denominator == '0) ? fadd_pkg::VALUE_BITS'(1)
                                                        : {1'b0, req_data.first_denominator};
            d_ff <= (req_data.second_denominator == '0) ? fadd_pkg::VALUE_BITS'(1)
                                                         : {1'b0, req_data.second_denominator};
         end
         fadd_pkg::ST_MUL_CB:   rnum_ff <= product_ff;
         fadd_pkg::ST_MUL_BD:   rnum_ff <= rnum_ff + product_ff;
         fadd_pkg::ST_GCD_GO:   rden_ff <= product_ff[fadd_pkg::DEN_W-1:0];
         fadd_pkg::ST_NUM_WAIT: if (div_status.done) qmag_ff <= quot;
         fadd_pkg::ST_DEN_WAIT: if (div_status.done) qden_ff <= quot;
         fadd_pkg::ST_CLASSIFY: begin
            whole_ff <= '0;
            rem_ff   <= '0;
            if (qden_ff == fadd_pkg::MAG_W'(1) || qmag_ff == '0) begin
               form_ff <= fadd_pkg::FORM_INTEGER;
            end else if (!rnum_ff[fadd_pkg::NUM_W-1] && qmag_ff > qden_ff) begin
               form_ff <= fadd_pkg::FORM_MIXED;
            end else begin
               form_ff <= fadd_pkg::FORM_PROPER;
            end
         end
         fadd_pkg::ST_MIX_WAIT: begin
            if (div_status.done) begin
               whole_ff <= quot;
               rem_ff   <= div_rem;
            end
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.raw_numerator       <= rnum_ff;
         rsp_ff.raw_denominator     <= rden_ff;
         rsp_ff.reduced_numerator   <= rnum_ff[fadd_pkg::NUM_W-1]
                                       ? -{1'b0, qmag_ff} : {1'b0, qmag_ff};
         rsp_ff.reduced_denominator <= qden_ff[fadd_pkg::DEN_W-1:0];
         rsp_ff.whole_part          <= whole_ff;
         rsp_ff.remainder_numerator <= rem_ff[fadd_pkg::DEN_W-1:0];
         rsp_ff.form                <= form_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the fraction adder: each accepted item's two fractions are summed,
// reduced by the gcd of the magnitudes and classified by a local predictor.
// Every returned item is compared field by field in order of acceptance.
// Directed edge cases come first, then random items with random stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 250;
   localparam int REPORT_LIMIT = 10;

   // holds the reduced sums expected back from the block, oldest first
   class sum_scoreboard;
      fadd_pkg::rsp_type expected_sums[$];
      int unsigned       mismatches;
      int unsigned       checked;
      int unsigned       zero_dens;
      int unsigned       form_seen[3];

      function new();
         mismatches = 0;
         checked    = 0;
         zero_dens  = 0;
         form_seen  = '{0, 0, 0};
      endfunction

      // sum a/b + c/d, reduce to lowest terms and classify
      function fadd_pkg::rsp_type reduce_sum(fadd_pkg::req_type r);
         fadd_pkg::rsp_type res;
         longint  a, b, c, d, rnum, rden, mag, x, y, t, qmag, qden, qnum;
         a = longint'($signed(r.first_numerator));
         c = longint'($signed(r.second_numerator));
         b = (r.first_denominator == 0) ? 1 : longint'(r.first_denominator);
         d = (r.second_denominator == 0) ? 1 : longint'(r.second_denominator);
         rnum = a * d + c * b;
         rden = b * d;
         mag  = (rnum < 0) ? -rnum : rnum;
         // euclid on the magnitudes; rden is never zero so gcd >= 1
         x = mag;
         y = rden;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         qmag = mag / x;
         qden = rden / x;
         qnum = (rnum < 0) ? -qmag : qmag;
         res = '0;
         res.raw_numerator       = rnum[fadd_pkg::NUM_W-1:0];
         res.raw_denominator     = rden[fadd_pkg::DEN_W-1:0];
         res.reduced_numerator   = qnum[fadd_pkg::NUM_W-1:0];
         res.reduced_denominator = qden[fadd_pkg::DEN_W-1:0];
         if (qden == 1 || qnum == 0) begin
            res.form = fadd_pkg::FORM_INTEGER;
         end else if (qnum > 0 && qmag > qden) begin
            res.form                = fadd_pkg::FORM_MIXED;
            res.whole_part          = fadd_pkg::WHOLE_W'(qmag / qden);
            res.remainder_numerator = fadd_pkg::DEN_W'(qmag % qden);
         end else begin
            res.form = fadd_pkg::FORM_PROPER;
         end
         return res;
      endfunction

      function void note_request(fadd_pkg::req_type r);
         if (r.first_denominator == 0 || r.second_denominator == 0) zero_dens++;
         expected_sums.push_back(reduce_sum(r));
      endfunction

      function void show_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
         if (want !== got) $display("   %s: expected %0d, got %0d", name, want, got);
      endfunction

      function void check_result(fadd_pkg::rsp_type got);
         fadd_pkg::rsp_type want;
         if (expected_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result item with nothing outstanding: raw %0d/%0d",
                        $signed(got.raw_numerator), got.raw_denominator);
            return;
         end
         want = expected_sums.pop_front();
         checked++;
         form_seen[want.form]++;
         if (got.raw_numerator !== want.raw_numerator ||
             got.raw_denominator !== want.raw_denominator ||
             got.reduced_numerator !== want.reduced_numerator ||
             got.reduced_denominator !== want.reduced_denominator ||
             got.whole_part !== want.whole_part ||
             got.remainder_numerator !== want.remainder_numerator ||
             got.form !== want.form) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("mismatch on result item %0d at %0t:", checked, $realtime);
               show_field("raw_numerator", $signed(want.raw_numerator),
                          $signed(got.raw_numerator));
               show_field("raw_denominator", want.raw_denominator, got.raw_denominator);
               show_field("reduced_numerator", $signed(want.reduced_numerator),
                          $signed(got.reduced_numerator));
               show_field("reduced_denominator", want.reduced_denominator,
                          got.reduced_denominator);
               show_field("whole_part", want.whole_part, got.whole_part);
               show_field("remainder_numerator", want.remainder_numerator,
                          got.remainder_numerator);
               show_field("form", want.form, got.form);
            end
         end
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   fadd_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   fadd_pkg::rsp_type rsp_data;
   bit                quiet_tail;
   bit                calm;

   sum_scoreboard sb = new();

   fraction_add_and_reduce dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // note accepted inputs and check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, sb.pending());
      $display("[fraction_add_and_reduce] ERROR");
      $finish;
   end

   // result-side backpressure in random bursts
   initial begin
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      forever begin
         repeat ($urandom_range(1, 40)) @(negedge clock);
         if (!quiet_tail && $urandom_range(0, 3) != 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic fadd_pkg::req_type make_req(int a, int b, int c, int d);
      fadd_pkg::req_type r;
      r.first_numerator    = a[fadd_pkg::VALUE_BITS-1:0];
      r.first_denominator  = b[fadd_pkg::DEN_IN_W-1:0];
      r.second_numerator   = c[fadd_pkg::VALUE_BITS-1:0];
      r.second_denominator = d[fadd_pkg::DEN_IN_W-1:0];
      return r;
   endfunction

   function automatic int pick_numerator_edge();
      case ($urandom_range(0, 4))
         0:       return -32768;
         1:       return -1;
         2:       return 0;
         3:       return 1;
         default: return 32767;
      endcase
   endfunction

   function automatic int pick_denominator_edge();
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return 1;
         2:       return 2;
         3:       return 32766;
         default: return 32767;
      endcase
   endfunction

   // random item of one of several flavors
   function automatic fadd_pkg::req_type random_request();
      fadd_pkg::req_type r;
      int unsigned       kind;
      int                a, b;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: begin
            r.first_numerator    = 16'($urandom());
            r.first_denominator  = 15'($urandom());
            r.second_numerator   = 16'($urandom());
            r.second_denominator = 15'($urandom());
         end
         4, 5: begin
            r = make_req(int'($urandom_range(0, 40)) - 20, $urandom_range(0, 12),
                         int'($urandom_range(0, 40)) - 20, $urandom_range(0, 12));
         end
         6: begin
            // opposite fractions that cancel
            a = int'($urandom_range(0, 65534)) - 32767;
            b = $urandom_range(1, 32767);
            r = make_req(a, b, -a, b);
         end
         7: begin
            // power-of-two denominators give large common factors
            r = make_req(int'($urandom_range(0, 65535)) - 32768, 1 << $urandom_range(0, 14),
                         int'($urandom_range(0, 65535)) - 32768, 1 << $urandom_range(0, 14));
         end
         8: begin
            r = make_req(int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 1),
                         int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 1));
         end
         default: begin
            r = make_req(pick_numerator_edge(), pick_denominator_edge(),
                         pick_numerator_edge(), pick_denominator_edge());
         end
      endcase
      return r;
   endfunction

   // present one item and hold it until accepted
   task automatic send_request(fadd_pkg::req_type r);
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic maybe_idle();
      int n;
      if (!quiet_tail && !calm && $urandom_range(0, 2) == 0) begin
         n = $urandom_range(1, 7);
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // main sequence
   initial begin
      fadd_pkg::req_type directed[$];
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      quiet_tail = 1'b0;
      calm       = 1'b0;

      // zero denominators, zero sums, all forms, extremes of the fields
      directed.push_back(make_req(0, 0, 0, 0));
      directed.push_back(make_req(1, 2, -1, 2));
      directed.push_back(make_req(-1, 0, 1, 0));
      directed.push_back(make_req(3, 0, 5, 0));
      directed.push_back(make_req(-32768, 1, -32768, 1));
      directed.push_back(make_req(32767, 32767, 32767, 32767));
      directed.push_back(make_req(-32768, 32767, -32768, 32767));
      directed.push_back(make_req(32767, 1, 1, 32767));
      directed.push_back(make_req(7, 2, 0, 1));
      directed.push_back(make_req(1, 3, 1, 5));
      directed.push_back(make_req(-1, 3, 0, 1));
      directed.push_back(make_req(-7, 2, 0, 5));
      directed.push_back(make_req(-4, 2, 0, 1));
      directed.push_back(make_req(32767, 32767, -32768, 1));
      directed.push_back(make_req(5, 32767, 0, 32767));
      directed.push_back(make_req(1, 16384, 1, 16384));
      directed.push_back(make_req(6, 4, 0, 9));
      directed.push_back(make_req(32767, 2, 32767, 2));
      directed.push_back(make_req(10, 6, 5, 15));
      directed.push_back(make_req(0, 7, 3, 7));
      directed.push_back(make_req(-32768, 32767, 32767, 32767));
      directed.push_back(make_req(1, 1, 0, 1));
      directed.push_back(make_req(3, 2, 0, 32767));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         maybe_idle();
         send_request(directed[i]);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_ITEMS * 85 / 100) quiet_tail = 1'b1;
         maybe_idle();
         send_request(random_request());
      end
      req_valid = 1'b0;

      // drain, then allow for any stray result
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d sums: %0d integer, %0d mixed, %0d proper or negative",
               sb.checked, sb.form_seen[fadd_pkg::FORM_INTEGER],
               sb.form_seen[fadd_pkg::FORM_MIXED], sb.form_seen[fadd_pkg::FORM_PROPER]);
      $display("%0d items carried a zero denominator; %0d mismatching items",
               sb.zero_dens, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("[fraction_add_and_reduce] OK");
      end else begin
         $display("[fraction_add_and_reduce] ERROR");
      end
      $finish;
   end

endmodule

// File: fraction_add_and_reduce.f
rtl/fadd_pkg.sv
rtl/fadd_mul.sv
rtl/fadd_gcd.sv
rtl/fadd_div.sv
rtl/fraction_add_and_reduce.sv
dv/testbench.sv
